### sv/qaa_pkg.sv
// Shared types and constants for the quaternion to axis-angle converter.
package qaa_pkg;

	localparam int STEPS = 16;
	localparam logic [15:0] ANGLE_PI_Q13 = 16'd25736;
	localparam logic [17:0] ANGLE_PI_Q16 = 18'd205887;
	localparam logic signed [19:0] ANGLE_HALF_PI_Q16 = 20'sd102944;
	localparam logic [16:0] ATAN_TAB [STEPS] = '{
		17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
		17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
	};

	localparam logic [2:0] ADDR_DEGENERATE_LIMIT = 3'd0;
	localparam logic [2:0] ADDR_HALF_TURN_LIMIT = 3'd4;

	typedef struct packed {
		logic neg;
		logic [60:0] rem;
		logic [48:0] prod;
		logic [15:0] quo;
	} lane_t;

	typedef struct packed {
		logic [31:0] s2;
		logic [31:0] sq_rem;
		logic [15:0] root;
		logic [15:0] wmag;
		logic wneg;
		logic degen;
		logic half;
		lane_t [2:0] lanes;
	} root_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic wneg;
		logic degen;
		logic half;
		logic [2:0] neg;
		logic [2:0][15:0] quo;
	} cordic_t;

endpackage

### sv/qaa_root_stage.sv
// One digit step of the three axis divisions and the integer square root.
module qaa_root_stage import qaa_pkg::*; #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input root_t in_data,
	output logic out_valid,
	output root_t out_data
);

	localparam int B = 15 - STEP;

	root_t nxt;
	logic vld_s1;
	root_t data_s1;

	always_comb begin
		logic [65:0] s2_sh;
		logic [65:0] term;
		logic [33:0] sq_term;
		logic ok;
		nxt = in_data;
		s2_sh = {34'd0, in_data.s2} << B;
		for (int l = 0; l < 3; l++) begin
			term = (({16'd0, in_data.lanes[l].prod, 1'b0}) + s2_sh) << B;
			ok = (B == 15) || !in_data.lanes[l].quo[15];
			if (ok && term <= {5'd0, in_data.lanes[l].rem}) begin
				nxt.lanes[l].rem = in_data.lanes[l].rem - term[60:0];
				nxt.lanes[l].prod = in_data.lanes[l].prod + s2_sh[48:0];
				nxt.lanes[l].quo = in_data.lanes[l].quo | (16'd1 << B);
			end
		end
		sq_term = ({18'd0, in_data.root} << (B + 1)) + (34'd1 << (2 * B));
		if (sq_term <= {2'd0, in_data.sq_rem}) begin
			nxt.sq_rem = in_data.sq_rem - sq_term[31:0];
			nxt.root = in_data.root | (16'd1 << B);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data = data_s1;

endmodule

### sv/qaa_cordic_stage.sv
// One vectoring rotation of the arctangent pipeline.
module qaa_cordic_stage import qaa_pkg::*; #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input cordic_t in_data,
	output logic out_valid,
	output cordic_t out_data
);

	localparam logic signed [19:0] ATAN_STEP = {3'd0, ATAN_TAB[STEP]};

	cordic_t nxt;
	logic vld_s1;
	cordic_t data_s1;

	always_comb begin
		logic signed [19:0] xs;
		logic signed [19:0] ys;
		nxt = in_data;
		xs = in_data.x >>> STEP;
		ys = in_data.y >>> STEP;
		if (!in_data.y[19]) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ATAN_STEP;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data = data_s1;

endmodule

### sv/quaternion_to_axis_angle.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output register.
// Depth is set by the 16 digit stages of the axis division and square root
// and the 16 rotation stages of the arctangent.
// Reset clears all valid bits and sets both limit registers to 1.
module quaternion_to_axis_angle import qaa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic quat_valid,
	output logic quat_ready,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic signed [15:0] quat_w,
	output logic result_valid,
	input logic result_ready,
	output logic [15:0] angle_rad,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic axis_undefined
);

	logic [30:0] degen_limit_q;
	logic [14:0] half_limit_q;
	logic en;

	logic vld_s1;
	logic signed [15:0] x_s1, y_s1, z_s1, w_s1;
	logic vld_s2;
	logic [30:0] sqx_s2, sqy_s2, sqz_s2;
	logic nx_s2, ny_s2, nz_s2;
	logic [15:0] wmag_s2;
	logic wneg_s2;
	logic vld_s3;
	root_t root_s3;

	logic rv [STEPS+1];
	root_t rd [STEPS+1];
	logic cv [STEPS+1];
	cordic_t cd [STEPS+1];

	logic vld_s36;
	logic [15:0] ang_s36;
	logic [2:0][15:0] axis_s36;
	logic undef_s36;

	assign pready = 1'b1;
	assign en = !vld_s36 || result_ready;
	assign quat_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degen_limit_q <= 31'd1;
			half_limit_q <= 15'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_DEGENERATE_LIMIT) begin
				degen_limit_q <= pwdata[30:0];
			end else if (paddr == ADDR_HALF_TURN_LIMIT) begin
				half_limit_q <= pwdata[14:0];
			end
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_DEGENERATE_LIMIT) begin
			prdata = {1'b0, degen_limit_q};
		end else if (paddr == ADDR_HALF_TURN_LIMIT) begin
			prdata = {17'd0, half_limit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s36 <= 1'b0;
		end else if (en) begin
			vld_s1 <= quat_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s36 <= cv[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] px, py, pz;
		logic [32:0] sum;
		if (en) begin
			x_s1 <= quat_x;
			y_s1 <= quat_y;
			z_s1 <= quat_z;
			w_s1 <= quat_w;

			px = x_s1 * x_s1;
			py = y_s1 * y_s1;
			pz = z_s1 * z_s1;
			sqx_s2 <= px[30:0];
			sqy_s2 <= py[30:0];
			sqz_s2 <= pz[30:0];
			nx_s2 <= x_s1[15];
			ny_s2 <= y_s1[15];
			nz_s2 <= z_s1[15];
			wneg_s2 <= w_s1[15];
			wmag_s2 <= w_s1[15] ? 16'(-w_s1) : 16'(w_s1);

			sum = {2'd0, sqx_s2} + {2'd0, sqy_s2} + {2'd0, sqz_s2};
			root_s3.s2 <= sum[31:0];
			root_s3.sq_rem <= sum[31:0];
			root_s3.root <= 16'd0;
			root_s3.wmag <= wmag_s2;
			root_s3.wneg <= wneg_s2;
			root_s3.degen <= (sum == 33'd0) || (sum < {2'd0, degen_limit_q});
			root_s3.half <= {1'b0, wmag_s2} < {2'd0, half_limit_q};
			root_s3.lanes[0] <= '{neg: nx_s2, rem: {sqx_s2, 30'd0}, prod: '0, quo: '0};
			root_s3.lanes[1] <= '{neg: ny_s2, rem: {sqy_s2, 30'd0}, prod: '0, quo: '0};
			root_s3.lanes[2] <= '{neg: nz_s2, rem: {sqz_s2, 30'd0}, prod: '0, quo: '0};
		end
	end

	assign rv[0] = vld_s3;
	assign rd[0] = root_s3;

	for (genvar i = 0; i < STEPS; i++) begin : g_root
		qaa_root_stage #(.STEP(i)) u_root (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(rv[i]), .in_data(rd[i]),
			.out_valid(rv[i+1]), .out_data(rd[i+1])
		);
	end

	always_comb begin
		cd[0].x = {4'd0, rd[STEPS].wmag};
		cd[0].y = {4'd0, rd[STEPS].root};
		cd[0].z = '0;
		cd[0].wneg = rd[STEPS].wneg;
		cd[0].degen = rd[STEPS].degen;
		cd[0].half = rd[STEPS].half;
		for (int l = 0; l < 3; l++) begin
			cd[0].neg[l] = rd[STEPS].lanes[l].neg;
			cd[0].quo[l] = rd[STEPS].lanes[l].quo;
		end
	end
	assign cv[0] = rv[STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		qaa_cordic_stage #(.STEP(i)) u_cordic (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(cv[i]), .in_data(cd[i]),
			.out_valid(cv[i+1]), .out_data(cd[i+1])
		);
	end

	always_ff @(posedge clk) begin
		logic signed [19:0] zc;
		logic [17:0] zf;
		logic [18:0] zr;
		if (en) begin
			if (cd[STEPS].z[19]) begin
				zc = '0;
			end else if (cd[STEPS].z > ANGLE_HALF_PI_Q16) begin
				zc = ANGLE_HALF_PI_Q16;
			end else begin
				zc = cd[STEPS].z;
			end
			zf = cd[STEPS].wneg ? ANGLE_PI_Q16 - zc[17:0] : zc[17:0];
			zr = {1'b0, zf} + 19'd2;
			if (cd[STEPS].degen) begin
				ang_s36 <= 16'd0;
				axis_s36[0] <= 16'd32767;
				axis_s36[1] <= 16'd0;
				axis_s36[2] <= 16'd0;
				undef_s36 <= 1'b1;
			end else begin
				ang_s36 <= cd[STEPS].half ? ANGLE_PI_Q13 : zr[17:2];
				for (int l = 0; l < 3; l++) begin
					if (cd[STEPS].neg[l]) begin
						axis_s36[l] <= 16'(-cd[STEPS].quo[l]);
					end else if (cd[STEPS].quo[l][15]) begin
						axis_s36[l] <= 16'd32767;
					end else begin
						axis_s36[l] <= cd[STEPS].quo[l];
					end
				end
				undef_s36 <= 1'b0;
			end
		end
	end

	assign result_valid = vld_s36;
	assign angle_rad = ang_s36;
	assign axis_x = axis_s36[0];
	assign axis_y = axis_s36[1];
	assign axis_z = axis_s36[2];
	assign axis_undefined = undef_s36;

endmodule
